@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the checker files.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is high.
`define PSBE_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("psbe assertion failed");

// Next-cycle implication, ignored while reset is high.
`define PSBE_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("psbe assertion failed");

// Next-cycle implication that also holds across reset.
`define PSBE_ASSERT_NXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("psbe assertion failed");

`endif

@@ rtl/core/psbe_pkg.sv @@
// Shared widths, codes, types and helpers for the palette blit engine.
// No dependencies.
package psbe_pkg;

  localparam int ADDR_W     = 32;
  localparam int DIM_W      = 12;
  localparam int DIMREG_W   = 13;
  localparam int PITCH_W    = 16;
  localparam int PIX_W      = 8;
  localparam int ZOOM_W     = 3;
  localparam int TAB_AW     = 8;
  localparam int TAB_DEPTH  = 256;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [DIMREG_W-1:0] DIM_MAX = DIMREG_W'(1) << DIM_W;

  typedef enum logic [1:0] {
    MODE_PLAIN = 2'd0,
    MODE_REMAP = 2'd1,
    MODE_SHADE = 2'd2,
    MODE_BLACK = 2'd3
  } blend_mode_t;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_PIXEL = 1'b1
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BLEND_MODE   = 3'd0,
    CFG_BLIT_WIDTH   = 3'd1,
    CFG_BLIT_HEIGHT  = 3'd2,
    CFG_DEST_PITCH   = 3'd3,
    CFG_DEST_BASE    = 3'd4,
    CFG_SOURCE_BASE  = 3'd5,
    CFG_SRC_ROW_W    = 3'd6,
    CFG_ZOOM_SHIFT   = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [DIMREG_W-1:0] width;
    logic [DIMREG_W-1:0] height;
    logic [PITCH_W-1:0]  dest_pitch;
    logic [ADDR_W-1:0]   dest_base;
    logic [ADDR_W-1:0]   source_base;
    logic [PITCH_W-1:0]  src_row_width;
    logic [ZOOM_W-1:0]   zoom;
  } raster_cfg_t;

  typedef struct packed {
    logic [ADDR_W-1:0] dest_addr;
    logic [ADDR_W-1:0] src_off;
    logic              last;
  } pix_pos_t;

  typedef struct packed {
    blend_mode_t      mode;
    logic [PIX_W-1:0] src;
  } pix_ctl_t;

  // Zero acts as one, oversize clamps to the counter range.
  function automatic logic [DIM_W-1:0] last_index(input logic [DIMREG_W-1:0] dim);
    logic [DIM_W-1:0] res;
    if (dim == '0) begin
      res = '0;
    end else if (dim > DIM_MAX) begin
      res = '1;
    end else begin
      res = DIM_W'(dim - DIMREG_W'(1));
    end
    return res;
  endfunction

endpackage

@@ rtl/core/psbe_remap_ram.sv @@
// 256 x 8 remap table, one write and one registered read port.
// Depends on psbe_pkg.
module psbe_remap_ram
  import psbe_pkg::*;
(
  input  logic              clk,
  input  logic              wr_en,
  input  logic [TAB_AW-1:0] wr_addr,
  input  logic [PIX_W-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [TAB_AW-1:0] rd_addr,
  output logic [PIX_W-1:0]  rd_data
);

  logic [PIX_W-1:0] mem [TAB_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/core/psbe_raster.sv @@
// Raster counters: column/row count and destination/source address walk.
// Depends on psbe_pkg.
module psbe_raster
  import psbe_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  raster_cfg_t cfg,
  input  logic        step,
  output pix_pos_t    pos
);

  logic [DIM_W-1:0]  col;
  logic [DIM_W-1:0]  row;
  logic [ADDR_W-1:0] dest_row;
  logic [ADDR_W-1:0] src_row;
  logic [ADDR_W-1:0] dest_pix;
  logic [ADDR_W-1:0] src_pix;

  logic              start;
  logic              last_col;
  logic              last_row;
  logic [ADDR_W-1:0] d_row;
  logic [ADDR_W-1:0] s_row;
  logic [ADDR_W-1:0] d_pix;
  logic [ADDR_W-1:0] s_pix;
  logic [ADDR_W-1:0] src_stride;
  logic [ADDR_W-1:0] src_step;
  logic [ADDR_W-1:0] d_row_next;
  logic [ADDR_W-1:0] s_row_next;

  always_comb begin
    start      = (col == '0) && (row == '0);
    d_row      = start ? cfg.dest_base   : dest_row;
    s_row      = start ? cfg.source_base : src_row;
    d_pix      = start ? cfg.dest_base   : dest_pix;
    s_pix      = start ? cfg.source_base : src_pix;
    last_col   = col >= last_index(cfg.width);
    last_row   = row >= last_index(cfg.height);
    src_stride = ADDR_W'(cfg.src_row_width) << cfg.zoom;
    src_step   = ADDR_W'(1) << cfg.zoom;
    d_row_next = d_row + ADDR_W'(cfg.dest_pitch);
    s_row_next = s_row + src_stride;
  end

  assign pos.dest_addr = d_pix;
  assign pos.src_off   = s_pix;
  assign pos.last      = last_col && last_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      col      <= '0;
      row      <= '0;
      dest_row <= '0;
      src_row  <= '0;
      dest_pix <= '0;
      src_pix  <= '0;
    end else if (step) begin
      if (last_col) begin
        col <= '0;
        if (last_row) begin
          row <= '0;
        end else begin
          row      <= row + DIM_W'(1);
          dest_row <= d_row_next;
          src_row  <= s_row_next;
          dest_pix <= d_row_next;
          src_pix  <= s_row_next;
        end
      end else begin
        col      <= col + DIM_W'(1);
        dest_row <= d_row;
        src_row  <= s_row;
        dest_pix <= d_pix + ADDR_W'(1);
        src_pix  <= s_pix + src_step;
      end
    end
  end

endmodule

@@ rtl/core/psbe_blend.sv @@
// Lookup stage and output register: waits on the remap read, applies the
// blend mode and holds the result item. Depends on psbe_pkg.
module psbe_blend
  import psbe_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  pix_pos_t          pos_in,
  input  pix_ctl_t          ctl_in,
  input  logic [PIX_W-1:0]  ram_data,
  output logic              stage_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [ADDR_W-1:0] dest_address,
  output logic [ADDR_W-1:0] source_offset,
  output logic              write_enable,
  output logic [PIX_W-1:0]  write_data,
  output logic              last_pixel
);

  logic             s1_valid;
  pix_pos_t         s1_pos;
  pix_ctl_t         s1_ctl;
  logic             adv;
  logic             src_nz;
  logic [PIX_W-1:0] colour;
  logic             we_next;
  logic [PIX_W-1:0] wd_next;

  assign adv         = !out_valid || out_ready;
  assign stage_ready = !s1_valid || adv;

  always_comb begin
    src_nz = s1_ctl.src != '0;
    unique case (s1_ctl.mode)
      MODE_PLAIN: colour = s1_ctl.src;
      MODE_REMAP: colour = ram_data;
      MODE_SHADE: colour = src_nz ? ram_data : '0;
      MODE_BLACK: colour = '0;
      default:    colour = '0;
    endcase
    if (s1_ctl.mode == MODE_BLACK) begin
      we_next = src_nz;
      wd_next = '0;
    end else begin
      we_next = colour != '0;
      wd_next = colour;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (stage_ready) begin
        s1_valid <= take;
      end
      if (adv) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stage_ready && take) begin
      s1_pos <= pos_in;
      s1_ctl <= ctl_in;
    end
    if (adv && s1_valid) begin
      dest_address  <= s1_pos.dest_addr;
      source_offset <= s1_pos.src_off;
      last_pixel    <= s1_pos.last;
      write_enable  <= we_next;
      write_data    <= wd_next;
    end
  end

endmodule

@@ rtl/core/palette_sprite_blit_engine_core.sv @@
// Palette sprite blit engine top level: configuration registers, raster
// counters, remap RAM and blend/output stage. Depends on psbe_pkg.
//
// Takes one item per clock while in_ready is high. A load item writes one remap
// entry and gives no result; a pixel item gives one result, registered first
// in the lookup stage together with the synchronous remap RAM read, then in
// the output register. While a result waits, the lookup stage can still take
// one more pixel item; after that the input stalls until the result is taken,
// and in_ready follows out_ready in the same cycle.
// The remap table has no reset and needs no clearing pass; every entry
// read must have been loaded first. Counters restart after the last pixel.
module palette_sprite_blit_engine_core
  import psbe_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wr_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  opcode,
  input  logic [PIX_W-1:0]      table_index,
  input  logic [PIX_W-1:0]      table_value,
  input  logic [PIX_W-1:0]      source_pixel,
  input  logic [PIX_W-1:0]      dest_pixel,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [ADDR_W-1:0]     dest_address,
  output logic [ADDR_W-1:0]     source_offset,
  output logic                  write_enable,
  output logic [PIX_W-1:0]      write_data,
  output logic                  last_pixel
);

  blend_mode_t      blend_mode;
  raster_cfg_t      rcfg;
  logic             accept;
  logic             pix_take;
  logic             load;
  logic             stage_ready;
  pix_pos_t         pos;
  pix_ctl_t         ctl;
  logic [PIX_W-1:0] ram_data;
  logic [PIX_W-1:0] rd_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      blend_mode         <= MODE_PLAIN;
      rcfg.width         <= DIMREG_W'(1);
      rcfg.height        <= DIMREG_W'(1);
      rcfg.dest_pitch    <= PITCH_W'(1);
      rcfg.dest_base     <= '0;
      rcfg.source_base   <= '0;
      rcfg.src_row_width <= PITCH_W'(1);
      rcfg.zoom          <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_BLEND_MODE:  blend_mode         <= blend_mode_t'(cfg_wr_data[1:0]);
        CFG_BLIT_WIDTH:  rcfg.width         <= cfg_wr_data[DIMREG_W-1:0];
        CFG_BLIT_HEIGHT: rcfg.height        <= cfg_wr_data[DIMREG_W-1:0];
        CFG_DEST_PITCH:  rcfg.dest_pitch    <= cfg_wr_data[PITCH_W-1:0];
        CFG_DEST_BASE:   rcfg.dest_base     <= cfg_wr_data[ADDR_W-1:0];
        CFG_SOURCE_BASE: rcfg.source_base   <= cfg_wr_data[ADDR_W-1:0];
        CFG_SRC_ROW_W:   rcfg.src_row_width <= cfg_wr_data[PITCH_W-1:0];
        CFG_ZOOM_SHIFT:  rcfg.zoom          <= cfg_wr_data[ZOOM_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready = stage_ready;
  assign accept   = in_valid && in_ready;
  assign pix_take = accept && (opcode_t'(opcode) == OP_PIXEL);
  assign load     = accept && (opcode_t'(opcode) == OP_LOAD);
  assign rd_addr  = (blend_mode == MODE_SHADE) ? dest_pixel : source_pixel;

  assign ctl.mode = blend_mode;
  assign ctl.src  = source_pixel;

  psbe_raster u_raster (
    .clk  (clk),
    .rst  (rst),
    .cfg  (rcfg),
    .step (pix_take),
    .pos  (pos)
  );

  psbe_remap_ram u_ram (
    .clk     (clk),
    .wr_en   (load),
    .wr_addr (table_index),
    .wr_data (table_value),
    .rd_en   (pix_take),
    .rd_addr (rd_addr),
    .rd_data (ram_data)
  );

  psbe_blend u_blend (
    .clk           (clk),
    .rst           (rst),
    .take          (pix_take),
    .pos_in        (pos),
    .ctl_in        (ctl),
    .ram_data      (ram_data),
    .stage_ready   (stage_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .dest_address  (dest_address),
    .source_offset (source_offset),
    .write_enable  (write_enable),
    .write_data    (write_data),
    .last_pixel    (last_pixel)
  );

endmodule

@@ rtl/core/psbe_checker.sv @@
// Port-level checker for the blit engine top level, bound in below.
// Depends on psbe_pkg and assert_macros.svh.
`include "assert_macros.svh"

module psbe_checker
  import psbe_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [ADDR_W-1:0]     dest_address,
  input logic [ADDR_W-1:0]     source_offset,
  input logic                  write_enable,
  input logic [PIX_W-1:0]      write_data,
  input logic                  last_pixel
);

  // a stalled result item holds
  `PSBE_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(dest_address) && $stable(source_offset) && $stable(write_data) && $stable(last_pixel))

  // no stale result after reset
  `PSBE_ASSERT_NXT_ALWAYS(a_rst_empty, clk, rst, !out_valid)

  // suppressed write carries zero data
  `PSBE_ASSERT_IMP(a_wd_zero, clk, rst, out_valid && !write_enable, write_data == '0)

  // with the output empty the input never stalls
  `PSBE_ASSERT_IMP(a_no_bubble, clk, rst, !out_valid, in_ready)

endmodule

bind palette_sprite_blit_engine_core psbe_checker u_psbe_checker (.*);
